@@ sv/b64e_pkg.sv @@
// Package for the unpadded Base64 encoder: payload structs, phase codes,
// queue sizing and the sextet-to-ASCII alphabet function.
// No dependencies.
package b64e_pkg;

    // Position of the next byte inside its three-byte group.
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    // Depth of the queue between the byte classifier and the character emitter.
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_b64_in;

    typedef struct packed {
        logic [6:0] out_char;
        logic       out_last;
    } t_b64_out;

    // One classified byte: one or two sextets still to be turned into characters.
    typedef struct packed {
        logic [5:0] sext0;
        logic [5:0] sext1;
        logic       two;
        logic       last;
    } t_b64_entry;

    // Maps a sextet onto the standard Base64 alphabet.
    function automatic logic [6:0] sextet_to_ascii(input logic [5:0] s);
        logic [6:0] v;
        v = {1'b0, s};
        if (s < 6'd26) begin
            sextet_to_ascii = 7'h41 + v;
        end else if (s < 6'd52) begin
            sextet_to_ascii = 7'h61 + v - 7'd26;
        end else if (s < 6'd62) begin
            sextet_to_ascii = 7'h30 + v - 7'd52;
        end else if (s == 6'd62) begin
            sextet_to_ascii = 7'h2b;
        end else begin
            sextet_to_ascii = 7'h2f;
        end
    endfunction

endpackage

@@ sv/base64_encoder_unpadded.sv @@
// Top level of the unpadded Base64 encoder.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Usage:
// The input channel (i_valid, i_data, o_stall) takes one raw byte per word,
// with is_last marking the final byte of a string. The output channel
// (o_valid, o_data, i_stall) delivers one Base64 character per word, with
// out_last set on the final character of the encoded string. No '=' padding
// is produced: a trailing one- or two-byte group yields two or three
// characters with the remaining bits zero filled.
// Each byte is first written into the queue; its first character is then
// loaded into the output register. Throughput is set by the output register,
// which presents one character per cycle while i_stall is low: bytes that
// give one character flow at one per cycle, bytes that give two hold the
// queue head for both characters. A four-entry queue between the byte
// classifier and the character emitter absorbs the difference.
// Reset clears the group phase and carry bits, empties the queue and drops
// the output register. When the receiver stalls, the current character holds
// steady; the queue keeps taking bytes until it fills, then o_stall rises.
module base64_encoder_unpadded import b64e_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_b64_in  i_data,
    output logic     o_stall,
    output logic     o_valid,
    output t_b64_out o_data,
    input  logic     i_stall
);

    // Front end to queue.
    logic       w_push;
    t_b64_entry w_push_entry;
    logic       w_full;

    // Queue to back end.
    logic       w_q_valid;
    t_b64_entry w_q_entry;
    logic       w_pop;

    // Classifies each byte by its place in the group and splits out the sextets.
    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .i_q_full (w_full),
        .o_stall  (o_stall),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    b64e_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_full   (w_full),
        .o_valid  (w_q_valid),
        .o_entry  (w_q_entry)
    );

    // Emits the characters of each queued byte, one per cycle while i_stall is low.
    b64e_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_entry   (w_q_entry),
        .i_stall   (i_stall),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .o_data    (o_data)
    );

`ifndef SYNTHESIS
    // The front end must never write into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("queue written while full");

    // The back end only pops a queue that holds an entry.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue popped while empty");

    // Every character shown belongs to the Base64 alphabet.
    a_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_data.out_char >= 7'h41 && o_data.out_char <= 7'h5a) ||
                     (o_data.out_char >= 7'h61 && o_data.out_char <= 7'h7a) ||
                     (o_data.out_char >= 7'h30 && o_data.out_char <= 7'h39) ||
                     o_data.out_char == 7'h2b || o_data.out_char == 7'h2f))
        else $error("character outside the Base64 alphabet");
`endif

endmodule

@@ sv/b64e_front.sv @@
// Front end of the Base64 encoder: accepts bytes, tracks the group phase
// and carry bits, and splits each byte into one or two sextets.
// Depends on b64e_pkg.
module b64e_front import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_b64_in    i_data,
    input  logic       i_q_full,
    output logic       o_stall,
    output logic       o_push,
    output t_b64_entry o_entry
);

    logic [1:0] r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    logic [7:0] w_byte;
    logic       w_last;

    assign w_byte  = i_data.data_byte;
    assign w_last  = i_data.is_last;
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_entry.last = w_last;
        unique case (r_phase)
            PH_SECOND: begin
                o_entry.sext0 = {r_carry[1:0], w_byte[7:4]};
                o_entry.sext1 = {w_byte[3:0], 2'b00};
                o_entry.two   = w_last;
                n_phase       = PH_THIRD;
                n_carry       = w_byte[3:0];
            end
            PH_THIRD: begin
                o_entry.sext0 = {r_carry, w_byte[7:6]};
                o_entry.sext1 = w_byte[5:0];
                o_entry.two   = 1'b1;
                n_phase       = PH_FIRST;
                n_carry       = 4'd0;
            end
            default: begin
                // The first byte of a group, and the unused phase code.
                o_entry.sext0 = w_byte[7:2];
                o_entry.sext1 = {w_byte[1:0], 4'b0000};
                o_entry.two   = w_last;
                n_phase       = PH_SECOND;
                n_carry       = {2'b00, w_byte[1:0]};
            end
        endcase
        if (w_last) begin
            n_phase = PH_FIRST;
            n_carry = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_carry <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_carry <= n_carry;
        end
    end

endmodule

@@ sv/b64e_queue.sv @@
// Short queue of classified bytes between the encoder front and back ends.
// Depends on b64e_pkg.
module b64e_queue import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_b64_entry i_entry,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_b64_entry o_entry
);

    t_b64_entry             r_mem [QueueDepth];
    logic [QPtrW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [QCntW-1:0]       r_count;

    assign o_full  = (r_count == QCntW'(QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPtrW'(1);
            end
            r_count <= r_count + QCntW'(i_push) - QCntW'(i_pop);
        end
    end

endmodule

@@ sv/b64e_back.sv @@
// Back end of the Base64 encoder: takes classified bytes from the queue and
// emits one character per cycle into the output register unless the receiver stalls.
// Depends on b64e_pkg.
module b64e_back import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_b64_entry i_entry,
    input  logic       i_stall,
    output logic       o_pop,
    output logic       o_valid,
    output t_b64_out   o_data
);

    logic       r_valid;
    t_b64_out   r_data, n_data;
    logic       r_half;
    logic       w_load;
    logic [5:0] w_sext;

    assign w_load  = i_q_valid && (!r_valid || !i_stall);
    assign o_pop   = w_load && (r_half || !i_entry.two);
    assign w_sext  = r_half ? i_entry.sext1 : i_entry.sext0;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data.out_char = sextet_to_ascii(w_sext);
        n_data.out_last = i_entry.last && (r_half || !i_entry.two);
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_half  <= i_entry.two && !r_half;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the unpadded Base64 encoder (base64_encoder_unpadded).
// Depends on b64e_pkg for the payload structs and phase codes; needs only the RTL.
`timescale 1ns / 100ps

module tb_top;
    import b64e_pkg::*;

    // The cycle limit is a safety net for a run that hangs.
    localparam int CYCLE_LIMIT  = 200000;
    // A character passes through the internal queue and the output register, and the queue
    // holds four entries, so the drain leaves ample time for stragglers.
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 500;
    // Near the end of the stimulus, both sides stop idling.
    localparam int QUIET_TAIL   = 40;
    localparam int DIR_ROWS     = 22;

    // ASCII codes used in the hand-written expectations.
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_SLASH   = 7'h2f;
    localparam logic [6:0] CH_LOWER_W = 7'h77;
    localparam logic [6:0] CH_NONE    = 7'h00;

    // The alphabet, indexed by sextet value.
    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // One row of the directed table. When typed_cnt is nonzero, the row carries
    // its expected characters; otherwise the predictor supplies them.
    typedef struct packed {
        logic [7:0] data_val;
        logic       last;
        logic [1:0] typed_cnt;
        logic [6:0] ch0;
        logic       last0;
        logic [6:0] ch1;
        logic       last1;
    } t_dir_row;

    typedef struct packed {
        t_b64_in    word;
        logic [1:0] typed_cnt;
        t_b64_out   typed0;
        t_b64_out   typed1;
    } t_byte_item;

    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // Single zero byte right after reset: two 'A', the second one final.
        '{8'h00, 1'b1, 2'd2, CH_UPPER_A, 1'b0, CH_UPPER_A, 1'b1},
        // Single all-ones byte: '/' then the zero-filled remainder 'w'.
        '{8'hff, 1'b1, 2'd2, CH_SLASH,   1'b0, CH_LOWER_W, 1'b1},
        // Full group of all-ones bytes gives four '/'.
        '{8'hff, 1'b0, 2'd1, CH_SLASH,   1'b0, CH_NONE,    1'b0},
        '{8'hff, 1'b0, 2'd1, CH_SLASH,   1'b0, CH_NONE,    1'b0},
        '{8'hff, 1'b1, 2'd2, CH_SLASH,   1'b0, CH_SLASH,   1'b1},
        // Full group of zero bytes gives four 'A'.
        '{8'h00, 1'b0, 2'd1, CH_UPPER_A, 1'b0, CH_NONE,    1'b0},
        '{8'h00, 1'b0, 2'd1, CH_UPPER_A, 1'b0, CH_NONE,    1'b0},
        '{8'h00, 1'b1, 2'd2, CH_UPPER_A, 1'b0, CH_UPPER_A, 1'b1},
        // A full group with no last flag: the string goes on into the next rows.
        '{8'h4d, 1'b0, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0},
        '{8'h61, 1'b0, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0},
        '{8'h6e, 1'b0, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0},
        // The string ends two bytes later: the flush comes from the second position.
        '{8'h55, 1'b0, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0},
        '{8'haa, 1'b1, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0},
        // One-byte string with the top bit set.
        '{8'h80, 1'b1, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0},
        '{8'h01, 1'b0, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0},
        '{8'h02, 1'b0, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0},
        '{8'h03, 1'b0, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0},
        '{8'h7f, 1'b0, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0},
        '{8'h3f, 1'b1, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0},
        '{8'hc0, 1'b0, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0},
        '{8'h0f, 1'b0, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0},
        '{8'hf0, 1'b1, 2'd0, CH_NONE,    1'b0, CH_NONE,    1'b0}
    };

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    t_b64_in  i_data  = '0;
    logic     o_stall;
    logic     o_valid;
    t_b64_out o_data;
    logic     i_stall = 1'b0;

    base64_encoder_unpadded dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    t_byte_item byte_stream [$];      // every byte word to send, in order
    t_b64_out   pending_chars [$];    // characters still owed by the block
    int         bytes_taken = 0;
    int         send_idx    = 0;
    int         err_count   = 0;
    int         cycles      = 0;

    // Predictor state: position in the three-byte group and the leftover bits.
    logic [1:0] enc_phase = PH_FIRST;
    logic [3:0] enc_carry = 4'd0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    function automatic t_b64_out make_char(input logic [5:0] sextet, input logic last);
        t_b64_out c;
        byte      code;
        code       = B64_ALPHABET[sextet];
        c.out_char = code[6:0];
        c.out_last = last;
        return c;
    endfunction

    // Works out the characters caused by one byte and advances the group state.
    // A byte yields two characters on the third position of a group, or on any
    // position when it ends the string; otherwise one.
    task automatic encode_byte(input t_b64_in w, output int cnt,
                               output t_b64_out c0, output t_b64_out c1);
        logic [5:0] s0;
        logic [5:0] s1;
        logic       two;
        case (enc_phase)
            PH_SECOND: begin
                s0        = {enc_carry[1:0], w.data_byte[7:4]};
                s1        = {w.data_byte[3:0], 2'b00};
                two       = w.is_last;
                enc_phase = PH_THIRD;
                enc_carry = w.data_byte[3:0];
            end
            PH_THIRD: begin
                s0        = {enc_carry, w.data_byte[7:6]};
                s1        = w.data_byte[5:0];
                two       = 1'b1;
                enc_phase = PH_FIRST;
                enc_carry = 4'd0;
            end
            default: begin
                // The unused phase value falls in here as well.
                s0        = w.data_byte[7:2];
                s1        = {w.data_byte[1:0], 4'b0000};
                two       = w.is_last;
                enc_phase = PH_SECOND;
                enc_carry = {2'b00, w.data_byte[1:0]};
            end
        endcase
        // The end of a string always restarts the group.
        if (w.is_last) begin
            enc_phase = PH_FIRST;
            enc_carry = 4'd0;
        end
        cnt = two ? 2 : 1;
        c0  = make_char(s0, two ? 1'b0 : w.is_last);
        c1  = make_char(s1, w.is_last);
    endtask

    // Sender: a word may change only when nothing is offered or the offered
    // word was just taken. Random idle bursts fall between words.
    always @(posedge i_clk) begin : sender
        int  gap_left;
        logic quiet;
        quiet = (byte_stream.size() - send_idx) < QUIET_TAIL;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else if (!i_valid || !o_stall) begin
            if (gap_left > 0) begin
                i_valid  <= 1'b0;
                gap_left = gap_left - 1;
            end else if (send_idx < byte_stream.size()) begin
                if (!quiet && $urandom_range(0, 3) == 0) begin
                    i_valid  <= 1'b0;
                    gap_left = $urandom_range(0, 2);
                end else begin
                    i_valid  <= 1'b1;
                    i_data   <= byte_stream[send_idx].word;
                    send_idx = send_idx + 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls come in random bursts; no new burst starts in the quiet tail.
    always @(posedge i_clk) begin : receiver
        int  stall_left;
        logic quiet;
        quiet = (byte_stream.size() - send_idx) < QUIET_TAIL;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_stall    <= 1'b1;
            stall_left = stall_left - 1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            i_stall    <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: on every accepted byte, queue what it must produce; on every
    // accepted character, compare it with the oldest owed character.
    always @(posedge i_clk) begin : monitor
        t_byte_item item;
        t_b64_out   c0;
        t_b64_out   c1;
        t_b64_out   want;
        int         cnt;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                item = byte_stream[bytes_taken];
                bytes_taken = bytes_taken + 1;
                encode_byte(item.word, cnt, c0, c1);
                // Hand-typed rows override the predictor but still advance it.
                if (item.typed_cnt != 2'd0) begin
                    pending_chars.push_back(item.typed0);
                    if (item.typed_cnt == 2'd2) pending_chars.push_back(item.typed1);
                end else begin
                    pending_chars.push_back(c0);
                    if (cnt == 2) pending_chars.push_back(c1);
                end
            end
            if (o_valid && !i_stall) begin
                if (pending_chars.size() == 0) begin
                    $display("%0t: unexpected character: expected none, actual %h last %b",
                             $realtime, o_data.out_char, o_data.out_last);
                    err_count = err_count + 1;
                end else begin
                    want = pending_chars.pop_front();
                    if (o_data.out_char !== want.out_char) begin
                        $display("%0t: out_char mismatch: expected %h, actual %h",
                                 $realtime, want.out_char, o_data.out_char);
                        err_count = err_count + 1;
                    end
                    if (o_data.out_last !== want.out_last) begin
                        $display("%0t: out_last mismatch: expected %b, actual %b",
                                 $realtime, want.out_last, o_data.out_last);
                        err_count = err_count + 1;
                    end
                end
            end
        end
    end

    initial begin : main
        t_byte_item item;
        int         row;
        int         len;
        int         k;
        int         random_count;

        // Directed part: walk the table in order.
        for (row = 0; row < DIR_ROWS; row++) begin
            item.word.data_byte = DIR_TABLE[row].data_val;
            item.word.is_last   = DIR_TABLE[row].last;
            item.typed_cnt      = DIR_TABLE[row].typed_cnt;
            item.typed0         = {DIR_TABLE[row].ch0, DIR_TABLE[row].last0};
            item.typed1         = {DIR_TABLE[row].ch1, DIR_TABLE[row].last1};
            byte_stream.push_back(item);
        end

        // Random part: strings of mostly short lengths so that every group
        // position sees the last flag often, with some longer ones mixed in.
        // A few bytes are forced to the extremes.
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            for (k = 0; k < len; k++) begin
                case ($urandom_range(0, 15))
                    0:       item.word.data_byte = 8'h00;
                    1:       item.word.data_byte = 8'hff;
                    default: item.word.data_byte = 8'($urandom_range(0, 255));
                endcase
                item.word.is_last = (k == len - 1);
                item.typed_cnt    = 2'd0;
                item.typed0       = '0;
                item.typed1       = '0;
                byte_stream.push_back(item);
            end
            random_count = random_count + len;
        end

        // Synchronous reset held at the start, released once.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((bytes_taken < byte_stream.size() || pending_chars.size() != 0)
               && cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end

        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
        end else begin
            // Give the block time to show any character it should not produce.
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (err_count == 0 && pending_chars.size() == 0) begin
                $display("[ OK ] regression clean");
            end else begin
                $display("[FAIL] regression broken");
            end
        end
        $finish;
    end

endmodule
